// ===== sv/voxel_occupancy_label_fusion_top_macros.svh =====
// assertion macros for the voxel fusion block
`ifndef VOXEL_OCCUPANCY_LABEL_FUSION_TOP_MACROS_SVH
`define VOXEL_OCCUPANCY_LABEL_FUSION_TOP_MACROS_SVH
// implication, disabled while reset is asserted
`define VOLF_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);
// next-cycle implication, disabled while reset is asserted
`define VOLF_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);
`endif

// ===== sv/volf_pkg.sv =====
// package: shared types and constants of the voxel fusion block
`timescale 1ns / 1ps
package volf_pkg;
  localparam int unsigned NUM_REGS = 6;
  localparam logic [2:0] REG_VOTE_STEP = 3'd0;
  localparam logic [2:0] REG_VOTE_CAP = 3'd1;
  localparam logic [2:0] REG_PROB_HIT = 3'd2;
  localparam logic [2:0] REG_PROB_MISS = 3'd3;
  localparam logic [2:0] REG_ODDS_FLOOR = 3'd4;
  localparam logic [2:0] REG_ODDS_CEIL = 3'd5;
  localparam logic [15:0] HALF_Q16 = 16'd32768;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // the two log2 mantissas travelling along the cell chain
  typedef struct packed {
    logic [16:0] ma;
    logic [16:0] mb;
  } mant_pair_t;
endpackage

// ===== sv/volf_log_cell.sv =====
// one fraction-bit cell of the paired log2 chain
`timescale 1ns / 1ps
module volf_log_cell #(
  parameter int RW = 20
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  volf_pkg::mant_pair_t m_i,
  input  logic signed [RW-1:0] ra_i,
  input  logic signed [RW-1:0] rb_i,
  output volf_pkg::mant_pair_t m_o,
  output logic signed [RW-1:0] ra_o,
  output logic signed [RW-1:0] rb_o
);
  logic [33:0] sqa, sqb;
  logic [17:0] ta, tb;
  volf_pkg::mant_pair_t m_d, m_q;
  logic signed [RW-1:0] ra_d, rb_d, ra_q, rb_q;

  always_comb begin
    sqa = 34'(m_i.ma) * 34'(m_i.ma);
    sqb = 34'(m_i.mb) * 34'(m_i.mb);
    ta = sqa[33:16];
    tb = sqb[33:16];
    ra_d = {ra_i[RW-2:0], ta[17]};
    rb_d = {rb_i[RW-2:0], tb[17]};
    m_d.ma = ta[17] ? ta[17:1] : ta[16:0];
    m_d.mb = tb[17] ? tb[17:1] : tb[16:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= m_d;
      ra_q <= ra_d;
      rb_q <= rb_d;
    end
  end

  assign m_o = m_q;
  assign ra_o = ra_q;
  assign rb_o = rb_q;
endmodule

// ===== sv/voxel_occupancy_label_fusion_top.sv =====
// top level: label voting, probability, log2 cell chain, clamp
// pipeline: ODDS_FRAC_BITS + 2 register stages (seed register, log2 cells, output register)
// throughput: one voxel per cycle while the output is not stalled; the chain of log2 cells sets the latency
// the pipeline advances whenever the output register is free or being taken
// reset: configuration registers return to their defaults, pipeline valid bits clear
`timescale 1ns / 1ps
`include "voxel_occupancy_label_fusion_top_macros.svh"
module voxel_occupancy_label_fusion_top #(
  parameter int CLASS_BITS = 8,
  parameter int ODDS_FRAC_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            predicted_class_i,
  input  logic [16:0]           meas_weight_i,
  input  logic [7:0]            old_class_i,
  input  logic [15:0]           old_vote_i,
  input  logic signed [15:0]    old_odds_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            new_class_o,
  output logic [15:0]           new_vote_o,
  output logic signed [15:0]    new_odds_o,
  output logic                  seen_o
);
  localparam int NC = ODDS_FRAC_BITS;
  localparam int ST = NC + 2;
  localparam int RW = NC + 7;

  logic [15:0] step_q, cap_q, hit_q, miss_q;
  logic signed [15:0] lo_q, hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 16'd256;
      cap_q <= 16'd2560;
      hit_q <= 16'd45875;
      miss_q <= 16'd26214;
      lo_q <= -16'sd2943;
      hi_q <= 16'sd5135;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        volf_pkg::REG_VOTE_STEP: step_q <= cfg_data_i;
        volf_pkg::REG_VOTE_CAP: cap_q <= cfg_data_i;
        volf_pkg::REG_PROB_HIT: hit_q <= cfg_data_i;
        volf_pkg::REG_PROB_MISS: miss_q <= cfg_data_i;
        volf_pkg::REG_ODDS_FLOOR: lo_q <= cfg_data_i;
        volf_pkg::REG_ODDS_CEIL: hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline valid chain; stage ST-1 is the output register
  logic [ST-1:0] vld_q;
  logic adv;
  assign adv = !vld_q[ST-1] || out_ready_i;
  assign in_ready_o = adv;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[ST-2:0], in_valid_i};
  end

  // stage 0: voting and probability
  logic [CLASS_BITS-1:0] pc, oc, cls_d;
  logic [15:0] vote_d;
  logic [16:0] vsum, w;
  logic [15:0] pcls;
  logic signed [17:0] pdiff;
  logic signed [35:0] prod;
  logic [15:0] p;
  always_comb begin
    pc = CLASS_BITS'(predicted_class_i);
    oc = CLASS_BITS'(old_class_i);
    cls_d = oc;
    vote_d = old_vote_i;
    vsum = 17'(old_vote_i) + 17'(step_q);
    w = (meas_weight_i > volf_pkg::ONE_Q16) ? volf_pkg::ONE_Q16 : meas_weight_i;
    pcls = miss_q;
    if (pc != '0) begin
      pcls = hit_q;
      if (pc == oc) vote_d = (vsum < 17'(cap_q)) ? vsum[15:0] : cap_q;
      else if (old_vote_i < step_q) begin
        vote_d = step_q - old_vote_i;
        cls_d = pc;
      end else vote_d = old_vote_i - step_q;
    end
    pdiff = $signed({2'b00, pcls}) - $signed({2'b00, volf_pkg::HALF_Q16});
    prod = 36'(pdiff) * $signed({19'd0, w});
    p = 16'((36'sd2147483648 + prod) >>> 16);
  end

  // log2 seed: integer part and normalized mantissa for x in 1..65536
  function automatic logic [21:0] seed(input logic [16:0] x);
    logic [4:0] n;
    logic [16:0] m;
    n = 5'd0;
    for (int i = 0; i < 17; i++) if (x[i]) n = 5'(i);
    m = 17'(x << (5'd16 - n));
    return {n, m};
  endfunction

  logic [21:0] sa, sb;
  assign sa = seed({1'b0, p});
  assign sb = seed(volf_pkg::ONE_Q16 - {1'b0, p});

  logic [CLASS_BITS-1:0] cls_q [ST];
  logic [15:0] vote_q [ST];
  logic signed [15:0] odds_q [ST];
  logic ninf_q [ST];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls_q[0] <= cls_d;
      vote_q[0] <= vote_d;
      odds_q[0] <= old_odds_i;
      ninf_q[0] <= (p == 16'd0);
      for (int s = 1; s < ST; s++) begin
        cls_q[s] <= cls_q[s-1];
        vote_q[s] <= vote_q[s-1];
        odds_q[s] <= odds_q[s-1];
        ninf_q[s] <= ninf_q[s-1];
      end
    end
  end

  volf_pkg::mant_pair_t m_c [NC+1];
  logic signed [RW-1:0] ra_c [NC+1];
  logic signed [RW-1:0] rb_c [NC+1];
  volf_pkg::mant_pair_t seed_m_q;
  logic signed [RW-1:0] seed_ra_q, seed_rb_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      seed_m_q.ma <= sa[16:0];
      seed_m_q.mb <= sb[16:0];
      seed_ra_q <= RW'(sa[21:17]);
      seed_rb_q <= RW'(sb[21:17]);
    end
  end
  assign m_c[0] = seed_m_q;
  assign ra_c[0] = seed_ra_q;
  assign rb_c[0] = seed_rb_q;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    volf_log_cell #(.RW(RW)) u_cell (
      .clk_i(clk_i), .en_i(adv), .m_i(m_c[g]), .ra_i(ra_c[g]), .rb_i(rb_c[g]),
      .m_o(m_c[g+1]), .ra_o(ra_c[g+1]), .rb_o(rb_c[g+1])
    );
  end

  // final stage: add and clamp
  logic signed [RW+1:0] sumo, lo_x, hi_x;
  logic signed [15:0] odds_d;
  always_comb begin
    lo_x = (RW+2)'(lo_q);
    hi_x = (RW+2)'(hi_q);
    sumo = (RW+2)'(odds_q[ST-2]) + (RW+2)'(ra_c[NC]) - (RW+2)'(rb_c[NC]);
    if (ninf_q[ST-2] || sumo < lo_x) sumo = lo_x;
    if (sumo > hi_x) sumo = hi_x;
    odds_d = 16'(sumo);
  end

  logic signed [15:0] res_q;
  always_ff @(posedge clk_i) if (adv) res_q <= odds_d;

  assign out_valid_o = vld_q[ST-1];
  assign new_class_o = 8'(cls_q[ST-1]);
  assign new_vote_o = vote_q[ST-1];
  assign new_odds_o = res_q;
  assign seen_o = 1'b1;

  `VOLF_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o,
    "result lost while stalled")
  `VOLF_ASSERT_IMP(a_rdy, clk_i, rst_ni, !out_valid_o, in_ready_o,
    "input stalled with empty output")
  `VOLF_ASSERT_NXT(a_move, clk_i, rst_ni, in_valid_i && in_ready_o, vld_q[0],
    "accepted transaction not tracked")
endmodule

// ===== tb/sv/tb.sv =====
// testbench for the voxel occupancy and label fusion block
`timescale 1ns / 1ps
module tb;
  localparam int FRAC = 10;
  localparam int LAT = FRAC + 2;
  localparam int N_RANDOM = 1350;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic [7:0] pred;
    logic [16:0] w;
    logic [7:0] cls;
    logic [15:0] vote;
    logic signed [15:0] odds;
  } voxel_in_t;

  typedef struct packed {
    logic [7:0] cls;
    logic [15:0] vote;
    logic signed [15:0] odds;
    logic seen;
  } voxel_out_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [7:0] predicted_class_i, old_class_i;
  logic [16:0] meas_weight_i;
  logic [15:0] old_vote_i;
  logic signed [15:0] old_odds_i;
  logic out_valid_o, out_ready_i;
  logic [7:0] new_class_o;
  logic [15:0] new_vote_o;
  logic signed [15:0] new_odds_o;
  logic seen_o;

  voxel_occupancy_label_fusion_top dut (.*);

  logic [15:0] regs_m [volf_pkg::NUM_REGS];
  voxel_in_t pending_voxels[$];
  voxel_out_t fused_voxels[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_sender = 0;
  int burst_left = 0, gap_left = 0;
  int stall_phase = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // truncating log2 of x in 1..65536 with FRAC fraction bits
  function automatic longint log2_trunc(longint unsigned x);
    int n;
    longint unsigned m;
    longint r;
    n = 0;
    while (n < 16 && (x >> (n + 1)) != 0) n++;
    m = x << (16 - n);
    r = n;
    for (int i = 0; i < FRAC; i++) begin
      m = (m * m) >> 16;
      r = r * 2;
      if (m >= 64'd131072) begin
        r = r + 1;
        m = m >> 1;
      end
    end
    return r;
  endfunction

  function automatic voxel_out_t fuse_voxel(voxel_in_t v);
    voxel_out_t o;
    longint unsigned w;
    longint step, cap, lo, hi, pcls, sum, p, od, t;
    longint unsigned vote;
    logic [7:0] cls;
    w = 64'(v.w);
    if (w > 65536) w = 65536;
    vote = 64'(v.vote);
    cls = v.cls;
    step = 64'(regs_m[volf_pkg::REG_VOTE_STEP]);
    cap = 64'(regs_m[volf_pkg::REG_VOTE_CAP]);
    lo = 64'($signed(regs_m[volf_pkg::REG_ODDS_FLOOR]));
    hi = 64'($signed(regs_m[volf_pkg::REG_ODDS_CEIL]));
    od = 64'(v.odds);
    if (v.pred != 0) begin
      if (v.pred == v.cls) begin
        t = vote + step;
        vote = (t < cap) ? t : cap;
      end else if (vote < step) begin
        vote = step - vote;
        cls = v.pred;
      end else begin
        vote = vote - step;
      end
      pcls = 64'(regs_m[volf_pkg::REG_PROB_HIT]);
    end else begin
      pcls = 64'(regs_m[volf_pkg::REG_PROB_MISS]);
    end
    sum = 64'sd32768 * 65536 + (pcls - 32768) * longint'(w);
    p = sum >>> 16;
    if (p <= 0) begin
      od = lo;
    end else begin
      od = od + log2_trunc(p) - log2_trunc(65536 - p);
      if (od < lo) od = lo;
    end
    if (od > hi) od = hi;
    o.cls = cls;
    o.vote = vote[15:0];
    o.odds = od[15:0];
    o.seen = 1'b1;
    return o;
  endfunction

  // driver: bursts and gaps, payload held until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      predicted_class_i <= 0;
      meas_weight_i <= 0;
      old_class_i <= 0;
      old_vote_i <= 0;
      old_odds_i <= 0;
    end else begin
      automatic bit done = in_valid_i && in_ready_o;
      if (done) fused_voxels.push_back(fuse_voxel({predicted_class_i, meas_weight_i,
          old_class_i, old_vote_i, old_odds_i}));
      if (!in_valid_i || done) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        if (!hold_sender && gap_left == 0 && pending_voxels.size() > 0) begin
          automatic voxel_in_t v = pending_voxels.pop_front();
          in_valid_i <= 1;
          predicted_class_i <= v.pred;
          meas_weight_i <= v.w;
          old_class_i <= v.cls;
          old_vote_i <= v.vote;
          old_odds_i <= v.odds;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 0;
    end else begin
      cycles <= cycles + 1;
      stall_phase <= (stall_phase + 1) % 200;
      if (stall_phase < 60) out_ready_i <= 1;
      else if (stall_phase < 120) out_ready_i <= ($urandom_range(0, 3) != 0);
      else out_ready_i <= ($urandom_range(0, 2) == 0);
      if (out_valid_o && out_ready_i) begin
        if (fused_voxels.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          automatic voxel_out_t e = fused_voxels.pop_front();
          if (new_class_o !== e.cls) begin
            $error("new_class exp %0d got %0d", e.cls, new_class_o); errors++;
          end
          if (new_vote_o !== e.vote) begin
            $error("new_vote exp %0d got %0d", e.vote, new_vote_o); errors++;
          end
          if (new_odds_o !== e.odds) begin
            $error("new_odds exp %0d got %0d", e.odds, new_odds_o); errors++;
          end
          if (seen_o !== e.seen) begin
            $error("seen exp %0d got %0d", e.seen, seen_o); errors++;
          end
        end
      end
    end
  end

  function automatic voxel_in_t rand_voxel();
    voxel_in_t v;
    int r;
    r = $urandom_range(0, 9);
    v.pred = (r < 3) ? 8'd0 : 8'($urandom_range(0, 255));
    v.cls = (r >= 3 && r < 6) ? v.pred : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: v.w = 17'd65536;
      1: v.w = 17'($urandom_range(65537, 131071));
      2: v.w = 17'($urandom_range(0, 16));
      default: v.w = 17'($urandom_range(0, 65536));
    endcase
    v.vote = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1024))
                                         : 16'($urandom_range(0, 65535));
    v.odds = 16'($urandom_range(0, 65535));
    return v;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx < volf_pkg::NUM_REGS) regs_m[idx] = val;
  endtask

  task automatic drain();
    while (pending_voxels.size() > 0 || in_valid_i || fused_voxels.size() > 0)
      @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [15:0] s, logic [15:0] c, logic [15:0] h,
                          logic [15:0] m, logic [15:0] f, logic [15:0] g);
    write_reg(volf_pkg::REG_VOTE_STEP, s);
    write_reg(volf_pkg::REG_VOTE_CAP, c);
    write_reg(volf_pkg::REG_PROB_HIT, h);
    write_reg(volf_pkg::REG_PROB_MISS, m);
    write_reg(volf_pkg::REG_ODDS_FLOOR, f);
    write_reg(volf_pkg::REG_ODDS_CEIL, g);
  endtask

  initial begin
    voxel_in_t v;
    cfg_we_i = 0;
    cfg_idx_i = 0;
    cfg_data_i = 0;
    regs_m[0] = 16'd256; regs_m[1] = 16'd2560; regs_m[2] = 16'd45875;
    regs_m[3] = 16'd26214; regs_m[4] = -16'sd2943; regs_m[5] = 16'd5135;
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: field extremes, every voting branch, saturation
    pending_voxels.push_back('{8'd0, 17'd0, 8'd0, 16'd0, 16'sh0000});
    pending_voxels.push_back('{8'd255, 17'h1FFFF, 8'd255, 16'hFFFF, 16'sh7FFF});
    pending_voxels.push_back('{8'd5, 17'd65536, 8'd5, 16'd2500, 16'sh8000});
    pending_voxels.push_back('{8'd5, 17'd65536, 8'd7, 16'd100, 16'sd0});
    pending_voxels.push_back('{8'd5, 17'd65536, 8'd7, 16'd300, 16'sd0});
    pending_voxels.push_back('{8'd0, 17'd65536, 8'd9, 16'd300, -16'sd3000});
    pending_voxels.push_back('{8'd1, 17'd65537, 8'd1, 16'd0, 16'sd5000});
    pending_voxels.push_back('{8'd170, 17'h0AAAA, 8'd85, 16'h5555, 16'sh2AAA});
    pending_voxels.push_back('{8'd85, 17'h15555, 8'd170, 16'hAAAA, 16'sh5555});
    drain();

    // zero probability (miss = 0, full weight), crossed clamps, cap below the old vote
    set_regs(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'sd100, -16'sd100);
    pending_voxels.push_back('{8'd0, 17'd65536, 8'd3, 16'd50, 16'sd0});
    pending_voxels.push_back('{8'd4, 17'd65536, 8'd4, 16'd50, 16'sd0});
    pending_voxels.push_back('{8'd4, 17'd1, 8'd2, 16'd0, 16'sd0});
    drain();
    set_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'sh8000, 16'sh7FFF);
    pending_voxels.push_back('{8'd7, 17'd65536, 8'd7, 16'hFFFF, 16'sd0});
    pending_voxels.push_back('{8'd7, 17'd65536, 8'd1, 16'd1, 16'sd0});
    pending_voxels.push_back('{8'd0, 17'd65536, 8'd1, 16'd1, 16'sd0});
    drain();
    write_reg(3'd7, 16'h1234);  // unknown index, ignored

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(16'd256, 16'd2560, 16'd45875, 16'd26214, -16'sd2943, 16'sd5135);
        1: set_regs(16'd1, 16'd65535, 16'd65535, 16'd1, 16'sh8000, 16'sh7FFF);
        2: set_regs(16'd40000, 16'd300, 16'd32768, 16'd32768, -16'sd10, 16'sd10);
        3: set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'sd500, -16'sd500);
        default: set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      endcase
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        v = rand_voxel();
        pending_voxels.push_back(v);
      end
      if (ph == 2) begin
        // hold off the sender until every result is back
        while (pending_voxels.size() > N_RANDOM / 12) @(posedge clk_i);
        hold_sender = 1;
        while (in_valid_i || fused_voxels.size() > 0) @(posedge clk_i);
        hold_sender = 0;
      end
      drain();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("DONE: errors detected");
    $finish;
  end
endmodule
